[design/flpm_pkg.sv]
// ----------------------------------------------------------------------------
// flpm_pkg: shared constants for the FIFO lot matcher
// Field widths, default sizes and the side code.
// ----------------------------------------------------------------------------
package flpm_pkg;
  localparam int unsigned SYMBOLS_DEF = 64;
  localparam int unsigned LOTS_DEF    = 64;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SYM_W   = 6;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 24;
  localparam int unsigned PNL_W   = 64;
  localparam logic SIDE_BUY = 1'b0;
endpackage

[design/fifo_lot_matching_pnl.sv]
// ----------------------------------------------------------------------------
// fifo_lot_matching_pnl: FIFO cost-basis matcher with realised PnL
// Keeps a ring of open lots per symbol in memories and matches trades.
// ----------------------------------------------------------------------------
// Timing: busy is high through S_QRD, S_DEC and S_PUSH on an append, and on a
// matching trade through S_QRD, S_DEC, then S_LRD, S_MUL and S_ACC for each lot
// it touches (read, multiply and accumulate per lot through the shared lot memory
// address), ending in S_PUSH or S_FIN; any result follows in the next cycle.
// One item at a time: the next item is taken only at an edge with busy low.
// After reset a clearing pass empties the queue table with busy high. No result stalls.
module fifo_lot_matching_pnl #(
  parameter int unsigned SYMBOLS         = flpm_pkg::SYMBOLS_DEF,
  parameter int unsigned LOTS_PER_SYMBOL = flpm_pkg::LOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [flpm_pkg::STAMP_W-1:0] in_stamp,
  input  logic [flpm_pkg::SYM_W-1:0]   in_symbol_index,
  input  logic                       in_side,
  input  logic [flpm_pkg::PRICE_W-1:0] in_price_ticks,
  input  logic [flpm_pkg::QTY_W-1:0]   in_quantity,
  output logic                       out_valid,
  output logic [flpm_pkg::STAMP_W-1:0] out_stamp,
  output logic [flpm_pkg::SYM_W-1:0]   out_symbol,
  output logic signed [flpm_pkg::PNL_W-1:0] out_realized_pnl,
  output logic                       out_lot_dropped,
  output logic                       out_pnl_saturated
);
  import flpm_pkg::*;

  localparam int unsigned SA = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned LA = $clog2(LOTS_PER_SYMBOL);
  localparam int unsigned CW = $clog2(LOTS_PER_SYMBOL + 1);
  // Queue table entry: side, count, head.
  localparam int unsigned QW = 1 + CW + LA;
  localparam int unsigned LD = SYMBOLS * LOTS_PER_SYMBOL;
  localparam int unsigned LAW = $clog2(LD);
  localparam logic [LA-1:0] LAST = LA'(LOTS_PER_SYMBOL - 1);
  localparam logic [CW-1:0] FULL = CW'(LOTS_PER_SYMBOL);
  localparam logic signed [PNL_W-1:0] PMAX = {1'b0, {(PNL_W-1){1'b1}}};
  localparam logic signed [PNL_W-1:0] PMIN = {1'b1, {(PNL_W-1){1'b0}}};

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_QRD  = 9'b000000100,
    S_DEC  = 9'b000001000,
    S_LRD  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_PUSH = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SA-1:0] clr_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [SA-1:0] sym_r;
  logic side_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0] qty_r;
  logic qside_r;
  logic [CW-1:0] cnt_r;
  logic [LA-1:0] head_r;
  logic signed [PNL_W-1:0] pnl_r;
  logic sat_r;
  logic [QTY_W-1:0] take_r;
  logic signed [PRICE_W:0] diff_r;
  logic signed [QTY_W+PRICE_W+1:0] term_r;

  // Queue table memory.
  logic q_we;
  logic [SA-1:0] q_addr;
  logic [QW-1:0] q_wd, q_rd;
  // Lot memories share one address.
  logic l_we;
  logic [LAW-1:0] l_addr;
  logic [QTY_W-1:0] lq_wd, lq_rd;
  logic [PRICE_W-1:0] lp_wd, lp_rd;

  flpm_ram #(.WIDTH(QW), .DEPTH(SYMBOLS)) u_qtab (
    .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd));
  flpm_ram #(.WIDTH(QTY_W), .DEPTH(LD)) u_lqty (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(lq_wd), .rdata(lq_rd));
  flpm_ram #(.WIDTH(PRICE_W), .DEPTH(LD)) u_lprc (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(lp_wd), .rdata(lp_rd));

  logic accept;
  logic in_range;
  logic [LA-1:0] tail;
  logic [LA:0] tail_sum;
  logic signed [PNL_W:0] acc_sum;
  logic signed [PNL_W-1:0] acc_new;
  logic acc_ovf;
  logic [LA-1:0] head_inc;

  assign busy = (state_r != S_IDLE);
  assign in_range = ({{(32-SYM_W){1'b0}}, in_symbol_index} < 32'(SYMBOLS));
  assign accept = start && !busy;

  // Tail position is head plus count, wrapped once.
  always_comb begin
    tail_sum = {1'b0, head_r} + (LA+1)'(cnt_r);
    if (tail_sum >= (LA+1)'(LOTS_PER_SYMBOL)) begin
      tail = LA'(tail_sum - (LA+1)'(LOTS_PER_SYMBOL));
    end else begin
      tail = LA'(tail_sum);
    end
    head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  end

  // Saturating add of the current term.
  always_comb begin
    acc_sum = {pnl_r[PNL_W-1], pnl_r} + (PNL_W+1)'(term_r);
    acc_ovf = 1'b0;
    acc_new = acc_sum[PNL_W-1:0];
    if (acc_sum > (PNL_W+1)'(PMAX)) begin
      acc_new = PMAX;
      acc_ovf = 1'b1;
    end else if (acc_sum < (PNL_W+1)'(PMIN)) begin
      acc_new = PMIN;
      acc_ovf = 1'b1;
    end
  end

  // Memory port control and next state.
  always_comb begin
    state_nxt = state_r;
    q_we = 1'b0;
    q_addr = sym_r;
    q_wd = {qside_r, cnt_r, head_r};
    l_we = 1'b0;
    l_addr = LAW'(sym_r) * LAW'(LOTS_PER_SYMBOL) + LAW'(head_r);
    lq_wd = qty_r;
    lp_wd = price_r;
    case (state_r)
      S_CLR: begin
        q_we = 1'b1;
        q_addr = clr_r;
        q_wd = '0;
        if (clr_r == SA'(SYMBOLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        q_addr = SA'(in_symbol_index);
        if (accept && in_range && in_quantity != '0) begin
          state_nxt = S_QRD;
        end
      end
      S_QRD: state_nxt = S_DEC;
      S_DEC: begin
        // Decide from the table entry latched in S_QRD.
        if (cnt_r == '0 || qside_r == side_r) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_LRD;
        end
      end
      S_LRD: state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (lq_rd > qty_r) begin
          // Partial fill on this lot: write back the remainder.
          l_we = 1'b1;
          lq_wd = lq_rd - qty_r;
          lp_wd = lp_rd;
          state_nxt = S_FIN;
        end else if (lq_rd == qty_r || cnt_r == CW'(1)) begin
          state_nxt = (lq_rd == qty_r) ? S_FIN : S_PUSH;
        end else begin
          // Fetch the next lot so that its data is ready in S_LRD.
          l_addr = LAW'(sym_r) * LAW'(LOTS_PER_SYMBOL) + LAW'(head_inc);
          state_nxt = S_LRD;
        end
      end
      S_PUSH: begin
        l_addr = LAW'(sym_r) * LAW'(LOTS_PER_SYMBOL) + LAW'(tail);
        if (cnt_r != FULL) begin
          l_we = 1'b1;
          q_we = 1'b1;
          q_wd = {qside_r, cnt_r + 1'b1, head_r};
        end
        state_nxt = S_IDLE;
      end
      S_FIN: begin
        q_we = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          stamp_r <= in_stamp;
          sym_r <= SA'(in_symbol_index);
          side_r <= in_side;
          price_r <= in_price_ticks;
          qty_r <= in_quantity;
          pnl_r <= '0;
          sat_r <= 1'b0;
        end
        S_QRD: begin
          qside_r <= q_rd[QW-1];
          cnt_r <= q_rd[QW-2 -: CW];
          head_r <= q_rd[LA-1:0];
        end
        S_DEC: begin
          if (cnt_r == '0) begin
            qside_r <= side_r;
          end
        end
        S_LRD: begin
          take_r <= (lq_rd <= qty_r) ? lq_rd : qty_r;
          if (qside_r == SIDE_BUY) begin
            diff_r <= $signed({1'b0, price_r}) - $signed({1'b0, lp_rd});
          end else begin
            diff_r <= $signed({1'b0, lp_rd}) - $signed({1'b0, price_r});
          end
        end
        S_ACC: begin
          pnl_r <= acc_new;
          sat_r <= sat_r | acc_ovf;
          if (lq_rd <= qty_r) begin
            qty_r <= qty_r - lq_rd;
            if (lq_rd != qty_r && cnt_r == CW'(1)) begin
              // Ring emptied with shares left: restart it on the trade side.
              head_r <= '0;
              cnt_r <= '0;
              qside_r <= side_r;
            end else begin
              cnt_r <= cnt_r - 1'b1;
              head_r <= head_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Matched flag, and the multiplier stage between the subtract and the accumulate.
  logic matched_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= 1'b0;
    end else begin
      if (state_r == S_IDLE) begin
        matched_r <= 1'b0;
      end else if (state_r == S_ACC) begin
        matched_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    term_r <= $signed({1'b0, take_r}) * diff_r;
  end

  // Result: a full append, or any matching trade.
  logic res_valid;
  assign res_valid = (state_r == S_PUSH && (cnt_r == FULL || matched_r)) ||
                     (state_r == S_FIN);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_valid;
    end
    if (res_valid) begin
      out_stamp <= stamp_r;
      out_symbol <= SYM_W'(sym_r);
      out_realized_pnl <= (state_r == S_PUSH && !matched_r) ? '0 : pnl_r;
      out_lot_dropped <= (state_r == S_PUSH && !matched_r);
      out_pnl_saturated <= matched_r & sat_r;
    end
  end
endmodule

[design/flpm_ram.sv]
// ----------------------------------------------------------------------------
// flpm_ram: generic single-port synchronous RAM
// One access per cycle; read data registered, returning old data on a write.
// ----------------------------------------------------------------------------
module flpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
